// File: design/mlru_pkg.sv
// Shared types and constants for the matrix LRU tracker.
// Used by mlru_cell and matrix_lru_tracker_core; depends on nothing.
package mlru_pkg;

  localparam int DEF_WAYS = 8;
  localparam int IDX_W    = 6;  // enough for the largest way count of 64
  localparam int CNT_W    = 7;  // holds a row count of up to 64
  localparam int WAY_W    = 3;  // width of the way fields on the ports

  typedef enum logic [1:0] {
    ACT_TOUCH = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } state_t;

  typedef struct packed {
    action_t            action;
    logic [WAY_W-1:0]   way_index;
  } in_beat_t;

  typedef struct packed {
    logic [WAY_W-1:0]   lru_way;
    logic [WAY_W-1:0]   mru_way;
  } out_beat_t;

  // Matrix update broadcast to every row cell.
  typedef struct packed {
    logic               touch;
    logic               clear;
    logic [IDX_W-1:0]   way;
  } row_cmd_t;

  // Running minimum and maximum handed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   lru_idx;
    logic [CNT_W-1:0]   lru_cnt;
    logic [IDX_W-1:0]   mru_idx;
    logic [CNT_W-1:0]   mru_cnt;
  } scan_tok_t;

endpackage

// File: design/matrix_lru_tracker_core.sv
// Top level of the matrix LRU tracker: control, chain of row cells, result register.
// Depends on mlru_pkg and mlru_cell.
//
// Usage:
//   in_valid/in_ready/in_data carry one beat: an action (touch, clear or query)
//   and the way to touch. out_valid/out_ready/out_data return one beat per
//   input beat with the least and most recently used ways after the action.
//   The matrix updates on the cycle the input beat is accepted. A scan token
//   then walks the row cells, one cell per cycle, keeping the running minimum
//   and maximum row count; the result goes to the hold register and from there
//   to the output register. One item is in flight at a time: the block takes
//   no new item until the token has passed the whole cell chain and the
//   control has gone from hold back to idle. The result register lets
//   the next item be accepted while the previous result is still waiting; if
//   the receiver stalls when a new result is ready, it is held until the
//   register frees and no new beat is taken.
//   Synchronous reset (rst_n low) zeroes the matrix and empties the block.
module matrix_lru_tracker_core #(
  parameter int WAYS = mlru_pkg::DEF_WAYS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mlru_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mlru_pkg::out_beat_t out_data
);

  mlru_pkg::state_t    state_r, state_nxt;
  logic                in_acc;
  logic                start_r;
  logic                fin;
  logic                load_out;
  mlru_pkg::row_cmd_t  cmd;
  mlru_pkg::scan_tok_t tok_link [WAYS+1];
  logic [WAYS-1:0]     tok_vld;
  mlru_pkg::out_beat_t hold_r;
  mlru_pkg::out_beat_t out_data_r;
  logic                out_valid_r;

  assign in_acc = in_valid && in_ready;
  assign fin    = tok_link[WAYS].valid;

  // A touch of a way beyond the configured count leaves the matrix alone.
  always_comb begin
    cmd.touch = in_acc && (in_data.action == mlru_pkg::ACT_TOUCH) &&
                (mlru_pkg::CNT_W'(in_data.way_index) < mlru_pkg::CNT_W'(WAYS));
    cmd.clear = in_acc && (in_data.action == mlru_pkg::ACT_CLEAR);
    cmd.way   = mlru_pkg::IDX_W'(in_data.way_index);
  end

  assign tok_link[0] = '{valid: start_r, default: '0};

  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    mlru_cell #(
      .WAYS (WAYS),
      .IDX  (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .tok_in  (tok_link[g]),
      .tok_out (tok_link[g+1])
    );
    assign tok_vld[g] = tok_link[g+1].valid;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlru_pkg::ST_IDLE:  if (in_acc) state_nxt = mlru_pkg::ST_SWEEP;
      mlru_pkg::ST_SWEEP: if (fin) state_nxt = mlru_pkg::ST_HOLD;
      mlru_pkg::ST_HOLD:  if (load_out) state_nxt = mlru_pkg::ST_IDLE;
      default:            state_nxt = mlru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      mlru_pkg::ST_IDLE:  in_ready = 1'b1;
      mlru_pkg::ST_SWEEP: ;
      mlru_pkg::ST_HOLD:  load_out = !out_valid_r || out_ready;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlru_pkg::ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fin) begin
      hold_r.lru_way <= tok_link[WAYS].lru_idx[mlru_pkg::WAY_W-1:0];
      hold_r.mru_way <= tok_link[WAYS].mru_idx[mlru_pkg::WAY_W-1:0];
    end
    if (load_out) begin
      out_data_r <= hold_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({start_r, tok_vld}))
    else $error("more than one scan token in the cell chain");

  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (start_r == 1'b0) && (tok_vld == '0))
    else $error("beat accepted while a scan is running");

  a_fin_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> state_r == mlru_pkg::ST_SWEEP)
    else $error("scan finished outside the sweep state");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

// File: design/mlru_cell.sv
// One row of the age matrix with its ones count and one step of the LRU/MRU scan.
// Depends on mlru_pkg for the command and scan token types.
module mlru_cell #(
  parameter int WAYS = mlru_pkg::DEF_WAYS,
  parameter int IDX  = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mlru_pkg::row_cmd_t  cmd,
  input  mlru_pkg::scan_tok_t tok_in,
  output mlru_pkg::scan_tok_t tok_out
);

  localparam logic [mlru_pkg::IDX_W-1:0] MY_IDX   = mlru_pkg::IDX_W'(IDX);
  localparam logic                       IS_HEAD  = (IDX == 0);
  localparam logic [mlru_pkg::CNT_W-1:0] FULL_CNT = mlru_pkg::CNT_W'(WAYS - 1);

  logic [WAYS-1:0]            row_r, row_nxt;
  logic [mlru_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WAYS-1:0]            col_mask;
  logic                       col_hit;
  mlru_pkg::scan_tok_t        tok_r, tok_nxt;

  assign col_mask = WAYS'(1) << cmd.way;
  assign col_hit  = |(row_r & col_mask);

  // The count is kept alongside the row so no popcount is needed.
  always_comb begin
    row_nxt = row_r;
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      row_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.touch) begin
      if (cmd.way == MY_IDX) begin
        row_nxt = ~col_mask;
        cnt_nxt = FULL_CNT;
      end else begin
        row_nxt = row_r & ~col_mask;
        cnt_nxt = cnt_r - mlru_pkg::CNT_W'(col_hit);
      end
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (IS_HEAD || (cnt_r < tok_in.lru_cnt)) begin
      tok_nxt.lru_idx = MY_IDX;
      tok_nxt.lru_cnt = cnt_r;
    end
    if (IS_HEAD || (cnt_r > tok_in.mru_cnt)) begin
      tok_nxt.mru_idx = MY_IDX;
      tok_nxt.mru_cnt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      cnt_r       <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.lru_idx <= tok_nxt.lru_idx;
    tok_r.lru_cnt <= tok_nxt.lru_cnt;
    tok_r.mru_idx <= tok_nxt.mru_idx;
    tok_r.mru_cnt <= tok_nxt.mru_cnt;
  end

  assign tok_out = tok_r;

`ifndef SYNTHESIS
  a_cnt_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == mlru_pkg::CNT_W'($countones(row_r)))
    else $error("row count out of step with row bits");

  a_diag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((row_r >> IDX) & WAYS'(1)) == '0)
    else $error("diagonal bit set in age matrix");

  a_tok_moves: assert property (@(posedge clk) disable iff (!rst_n)
    tok_in.valid |=> tok_out.valid)
    else $error("scan token lost in a cell");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for matrix_lru_tracker_core: directed and random access beats, each result
// checked against a local model of the age matrix. Depends on mlru_pkg and the core.
module testbench;

  localparam int WAYS = mlru_pkg::DEF_WAYS;
  localparam int LATENCY = WAYS + 2;
  localparam int HALF_PERIOD_NS = 6;
  localparam int RESET_CYCLES = 5;
  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused code, must act as a query
  localparam int RANDOM_ITEMS = 630;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mlru_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mlru_pkg::out_beat_t out_data;

  logic [WAYS-1:0]     age_rows [WAYS];
  mlru_pkg::out_beat_t pending_ways [$];
  mlru_pkg::out_beat_t want_ways;
  int                  mismatches = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;

  matrix_lru_tracker_core #(.WAYS(WAYS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  // Updates the local age matrix for one access and returns the ways it should report.
  function automatic mlru_pkg::out_beat_t apply_access(mlru_pkg::in_beat_t item);
    mlru_pkg::out_beat_t res;
    int                  fewest;
    int                  most;
    int                  ones;
    case (item.action)
      mlru_pkg::ACT_TOUCH: begin
        if (int'(item.way_index) < WAYS) begin
          age_rows[item.way_index] = '1;
          for (int i = 0; i < WAYS; i++) age_rows[i][item.way_index] = 1'b0;
        end
      end
      mlru_pkg::ACT_CLEAR: begin
        for (int i = 0; i < WAYS; i++) age_rows[i] = '0;
      end
      default: ;
    endcase
    res = '0;
    fewest = WAYS + 1;
    most = -1;
    for (int i = 0; i < WAYS; i++) begin
      ones = $countones(age_rows[i]);
      if (ones < fewest) begin
        fewest = ones;
        res.lru_way = mlru_pkg::WAY_W'(i);
      end
      if (ones > most) begin
        most = ones;
        res.mru_way = mlru_pkg::WAY_W'(i);
      end
    end
    return res;
  endfunction

  function automatic mlru_pkg::in_beat_t make_beat(logic [1:0] act,
                                                   logic [mlru_pkg::WAY_W-1:0] way);
    mlru_pkg::in_beat_t b;
    b.action = mlru_pkg::action_t'(act);
    b.way_index = way;
    return b;
  endfunction

  // Valid is left high after acceptance; the next call either updates the payload in
  // the same step or drops valid for an idle gap, so valid is never toggled in one step.
  task automatic send_beat(input mlru_pkg::in_beat_t item);
    int gap;
    bit took;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    pending_ways.push_back(apply_access(item));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_ways.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // The handshake is decided by values that are stable from the falling edge on.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_ways.size() == 0) begin
        $display("%0t: result beat with nothing pending: lru %0d mru %0d",
                 $time, out_data.lru_way, out_data.mru_way);
        mismatches++;
      end else begin
        want_ways = pending_ways.pop_front();
        if (out_data.lru_way !== want_ways.lru_way) begin
          $display("%0t: lru_way expected %0d actual %0d",
                   $time, want_ways.lru_way, out_data.lru_way);
          mismatches++;
        end
        if (out_data.mru_way !== want_ways.mru_way) begin
          $display("%0t: mru_way expected %0d actual %0d",
                   $time, want_ways.mru_way, out_data.mru_way);
          mismatches++;
        end
      end
    end
  end

  // Right after reset every row is equal, so both ways must read zero.
  task automatic test_reset_state();
    send_beat(make_beat(mlru_pkg::ACT_QUERY, 3'd7));
    send_beat(make_beat(ACT_SPARE, 3'd0));
    send_beat(make_beat(ACT_SPARE, 3'd5));
    wait_for_results();
  endtask

  task automatic test_touch_every_way();
    for (int w = 0; w < WAYS; w++) begin
      send_beat(make_beat(mlru_pkg::ACT_TOUCH, mlru_pkg::WAY_W'(w)));
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      send_beat(make_beat(mlru_pkg::ACT_TOUCH, mlru_pkg::WAY_W'(w)));
    end
    wait_for_results();
  endtask

  task automatic test_repeat_and_query();
    send_beat(make_beat(mlru_pkg::ACT_TOUCH, 3'd7));
    send_beat(make_beat(mlru_pkg::ACT_TOUCH, 3'd7));
    send_beat(make_beat(mlru_pkg::ACT_QUERY, 3'd0));
    send_beat(make_beat(mlru_pkg::ACT_TOUCH, 3'd0));
    send_beat(make_beat(ACT_SPARE, 3'd7));
    wait_for_results();
  endtask

  task automatic test_clear();
    send_beat(make_beat(mlru_pkg::ACT_CLEAR, 3'd7));
    send_beat(make_beat(mlru_pkg::ACT_QUERY, 3'd3));
    send_beat(make_beat(mlru_pkg::ACT_TOUCH, 3'd4));
    send_beat(make_beat(mlru_pkg::ACT_CLEAR, 3'd0));
    wait_for_results();
  endtask

  // Mostly touches so the matrix builds up a deep history; clears are kept rare.
  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    int         pick;
    logic [1:0] act;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) act = mlru_pkg::ACT_CLEAR;
      else if (pick < 12) act = mlru_pkg::ACT_QUERY;
      else if (pick < 17) act = ACT_SPARE;
      else act = mlru_pkg::ACT_TOUCH;
      send_beat(make_beat(act, mlru_pkg::WAY_W'($urandom_range(7))));
    end
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < WAYS; i++) age_rows[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_touch_every_way();
    test_repeat_and_query();
    test_clear();
    test_random_traffic(RANDOM_ITEMS, 10, 72);
    test_random_traffic(RANDOM_ITEMS, 72, 10);
    test_random_traffic(RANDOM_ITEMS, 0, 0);
    if (mismatches == 0 && pending_ways.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
